// ===== sv/wvd_pkg.sv =====
// Shared types and constants for the window violation detector.
package wvd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = 7;
	localparam int MAXV_W   = 7;
	localparam int CFG_W    = 7;
	localparam int IDX_W    = 1;

	localparam logic [IDX_W-1:0] REG_INSIDE_MODE   = 1'd0;
	localparam logic [IDX_W-1:0] REG_MAX_VIOLATORS = 1'd1;

	localparam logic             INSIDE_MODE_RST   = 1'b1;
	localparam logic [MAXV_W-1:0] MAX_VIOLATORS_RST = 7'd5;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// band under test, broadcast to every cell
	typedef struct packed {
		sample_t lo;
		sample_t hi;
		logic    in_mode;
	} band_t;

	// counting token handed from cell to cell
	typedef struct packed {
		logic             active;
		logic [CNT_W-1:0] count;
	} tok_t;

endpackage

// ===== sv/wvd_cell.sv =====
// One window cell: holds a sample, tests it against the band, adds to the passing count.
module wvd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  wvd_pkg::sample_t sample_in,
	input  logic            valid_in,
	output wvd_pkg::sample_t sample_out,
	output logic            valid_out,
	input  wvd_pkg::band_t  band,
	input  logic            advance,
	input  wvd_pkg::tok_t   tok_in,
	output wvd_pkg::tok_t   tok_out
);

	wvd_pkg::sample_t sample_q;
	logic             valid_q;
	wvd_pkg::tok_t    tok_q;
	logic             in_band;
	logic             hit;

	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= valid_in;
		end
	end

	// strict band test
	assign in_band = (sample_q > band.lo) && (sample_q < band.hi);
	assign hit     = valid_q && (band.in_mode ? in_band : !in_band);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance) begin
			tok_q.active <= tok_in.active;
			tok_q.count  <= tok_in.count + wvd_pkg::CNT_W'(hit);
		end
	end

	assign sample_out = sample_q;
	assign valid_out  = valid_q;
	assign tok_out    = tok_q;

endmodule

// ===== sv/window_violation_detector_unit.sv =====
// Top level: sliding window k-of-n band detector built as a chain of counting cells.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: sample, bound_a, bound_b
//  m_*     | out | m_tvalid/m_tready  | m_tdata: violation_count, flagged
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_wdata
//
// An accepted item launches a counting token via start_q; the token walks the cell
// chain one cell per cycle while not stalled, then its count loads the output register.
// The next item is accepted once the token has left the chain, while the previous
// result may still wait in the output register; a stalled result holds the token in
// the last cell. Reset empties the window (valid bits cleared) and loads register
// defaults.
module window_violation_detector_unit #(
	parameter int WINDOW_LEN = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // sample[15:0], bound_a[31:16], bound_b[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // violation_count[6:0], flagged[7]
	input  logic                        cfg_we,
	input  logic [wvd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [wvd_pkg::CFG_W-1:0]   cfg_wdata
);

	wvd_pkg::sample_t in_sample;
	wvd_pkg::sample_t in_a;
	wvd_pkg::sample_t in_b;

	logic                        inside_mode_q;
	logic [wvd_pkg::MAXV_W-1:0]  max_viol_q;
	wvd_pkg::sample_t            lo_q;
	wvd_pkg::sample_t            hi_q;
	wvd_pkg::band_t              band;

	logic busy_q;
	logic start_q;
	logic accept;
	logic done;
	logic stall;
	logic advance;
	logic load;

	logic                       m_tvalid_q;
	logic [wvd_pkg::CNT_W-1:0]  count_q;
	logic                       flag_q;

	wvd_pkg::sample_t samp_chain [WINDOW_LEN];
	logic             vld_chain  [WINDOW_LEN];
	wvd_pkg::tok_t    tok_chain  [WINDOW_LEN+1];
	logic [WINDOW_LEN:0] tok_active;

	assign in_sample = s_tdata[15:0];
	assign in_a      = s_tdata[31:16];
	assign in_b      = s_tdata[47:32];

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign done     = tok_chain[WINDOW_LEN].active;
	assign stall    = m_tvalid_q && !m_tready;
	assign advance  = !(done && stall);
	assign load     = done && !stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_mode_q <= wvd_pkg::INSIDE_MODE_RST;
			max_viol_q    <= wvd_pkg::MAX_VIOLATORS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wvd_pkg::REG_INSIDE_MODE:   inside_mode_q <= cfg_wdata[0];
				wvd_pkg::REG_MAX_VIOLATORS: max_viol_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// band limits, ordered
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= (in_a < in_b) ? in_a : in_b;
			hi_q <= (in_a < in_b) ? in_b : in_a;
		end
	end

	assign band = '{lo: lo_q, hi: hi_q, in_mode: inside_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign tok_chain[0] = '{active: start_q, count: '0};

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		wvd_pkg::sample_t cell_sample_in;
		logic             cell_valid_in;

		if (i == 0) begin : g_head
			assign cell_sample_in = in_sample;
			assign cell_valid_in  = 1'b1;
		end else begin : g_body
			assign cell_sample_in = samp_chain[i-1];
			assign cell_valid_in  = vld_chain[i-1];
		end

		wvd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (accept),
			.sample_in  (cell_sample_in),
			.valid_in   (cell_valid_in),
			.sample_out (samp_chain[i]),
			.valid_out  (vld_chain[i]),
			.band       (band),
			.advance    (advance),
			.tok_in     (tok_chain[i]),
			.tok_out    (tok_chain[i+1])
		);
	end

	for (genvar j = 0; j <= WINDOW_LEN; j++) begin : g_act
		assign tok_active[j] = tok_chain[j].active;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			count_q <= tok_chain[WINDOW_LEN].count;
			flag_q  <= tok_chain[WINDOW_LEN].count > max_viol_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {flag_q, count_q};

	// at most one item in flight through the chain
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_active))
		else $error("more than one counting token in the chain");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (tok_active == '0))
		else $error("ready while a token is still in the chain");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> start_q && busy_q)
		else $error("accepted item did not launch a token");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] <= wvd_pkg::CNT_W'(WINDOW_LEN)))
		else $error("count exceeds window length");

endmodule

// ===== test/tb_window_violation_detector_unit.sv =====
// Testbench for the sliding-window band detector: stream stimulus, self-checking count and flag.
`timescale 1ns / 1ps

module tb_window_violation_detector_unit;

	localparam int WINDOW_LEN  = 20;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		wvd_pkg::sample_t sample;
		wvd_pkg::sample_t bound_a;
		wvd_pkg::sample_t bound_b;
	} band_item_t;

	typedef struct {
		logic [wvd_pkg::CNT_W-1:0] count;
		logic                      flagged;
	} band_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata = '0;    // sample[15:0], bound_a[31:16], bound_b[47:32]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;         // violation_count[6:0], flagged[7]
	logic              cfg_we = 1'b0;
	logic [wvd_pkg::IDX_W-1:0]  cfg_index = '0;
	logic [wvd_pkg::CFG_W-1:0]  cfg_wdata = '0;

	band_item_t   item_q[$];
	band_result_t count_q[$];

	wvd_pkg::sample_t band_window[WINDOW_LEN];
	int      band_fill = 0;
	logic    mode_inside = wvd_pkg::INSIDE_MODE_RST;
	int      flag_limit = int'(wvd_pkg::MAX_VIOLATORS_RST);

	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int errors = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_send = 1'b0;
	bit s_fire = 1'b0;

	window_violation_detector_unit #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic band_result_t predict_band_count(wvd_pkg::sample_t s,
		wvd_pkg::sample_t a, wvd_pkg::sample_t b);
		band_result_t     r;
		wvd_pkg::sample_t lo;
		wvd_pkg::sample_t hi;
		int               hits;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (band_fill < WINDOW_LEN) begin
			band_window[band_fill] = s;
			band_fill++;
		end else begin
			for (int i = 0; i < WINDOW_LEN - 1; i++)
				band_window[i] = band_window[i+1];
			band_window[WINDOW_LEN-1] = s;
		end
		hits = 0;
		for (int i = 0; i < band_fill; i++)
			if (((band_window[i] > lo) && (band_window[i] < hi)) == mode_inside)
				hits++;
		r.count   = wvd_pkg::CNT_W'(hits);
		r.flagged = (hits > flag_limit);
		return r;
	endfunction

	function automatic wvd_pkg::sample_t rail_value();
		case ($urandom_range(0, 3))
			0: return wvd_pkg::sample_t'(-32768);
			1: return wvd_pkg::sample_t'(32767);
			2: return wvd_pkg::sample_t'(-1);
			default: return wvd_pkg::sample_t'(0);
		endcase
	endfunction

	// mostly samples clustered near base with a band around them; some full-range noise
	function automatic band_item_t make_item(int base);
		band_item_t it;
		int         pick;
		int         lo;
		int         hi;
		pick = $urandom_range(0, 19);
		if (pick < 3)
			it.sample = wvd_pkg::sample_t'($urandom);
		else if (pick == 3)
			it.sample = rail_value();
		else
			it.sample = wvd_pkg::sample_t'(base + $urandom_range(0, 600) - 300);
		lo = base - $urandom_range(0, 400);
		hi = base + $urandom_range(0, 400);
		pick = $urandom_range(0, 19);
		if (pick < 2) begin
			lo = hi;
		end else if (pick < 4) begin
			lo = int'(wvd_pkg::sample_t'($urandom));
			hi = int'(wvd_pkg::sample_t'($urandom));
		end else if (pick == 4) begin
			lo = -32768;
			hi = 32767;
		end else if (pick == 5) begin
			lo = int'(it.sample);
		end else if (pick == 6) begin
			hi = int'(it.sample);
		end
		if ($urandom_range(0, 1)) begin
			it.bound_a = wvd_pkg::sample_t'(lo);
			it.bound_b = wvd_pkg::sample_t'(hi);
		end else begin
			it.bound_a = wvd_pkg::sample_t'(hi);
			it.bound_b = wvd_pkg::sample_t'(lo);
		end
		return it;
	endfunction

	task automatic queue_item(input int s, input int a, input int b);
		band_item_t it;
		it.sample  = wvd_pkg::sample_t'(s);
		it.bound_a = wvd_pkg::sample_t'(a);
		it.bound_b = wvd_pkg::sample_t'(b);
		item_q = {item_q, it};
		n_queued++;
	endtask

	// called only while idle, both registers every time
	task automatic set_config(input logic in_mode, input logic [wvd_pkg::MAXV_W-1:0] limit);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= wvd_pkg::REG_INSIDE_MODE;
		cfg_wdata <= wvd_pkg::CFG_W'(in_mode);
		mode_inside = in_mode;
		@(negedge clk);
		cfg_index <= wvd_pkg::REG_MAX_VIOLATORS;
		cfg_wdata <= wvd_pkg::CFG_W'(limit);
		flag_limit = int'(limit);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int n, input int s_pct, input int r_pct, input bit drain);
		band_item_t it;
		int         base;
		int         mark;
		send_idle = s_pct;
		recv_idle = r_pct;
		base = $urandom_range(0, 60000) - 30000;
		mark = n_accepted;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 49) == 0)
				base = $urandom_range(0, 60000) - 30000;
			it = make_item(base);
			queue_item(int'(it.sample), int'(it.bound_a), int'(it.bound_b));
		end
		if (drain) begin
			wait (n_accepted >= mark + n / 2);
			hold_send = 1'b1;
			wait (n_checked == n_accepted && !s_tvalid);
			hold_send = 1'b0;
		end
		wait (n_checked == n_queued);
	endtask

	always @(negedge clk) begin : drive
		band_item_t it;
		bit         go;
		if (arst_n) begin
			if (!s_tvalid || s_fire) begin
				s_fire = 1'b0;
				go = !hold_send && item_q.size() != 0 && ($urandom_range(0, 99) >= send_idle);
				if (go) begin
					it = item_q.pop_front();
					s_tdata <= {it.bound_b, it.bound_a, it.sample};
				end
				s_tvalid <= go;
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin : watch
		band_result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** window_violation_detector_unit: FAILED **");
			$finish;
		end
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				count_q = {count_q, predict_band_count(s_tdata[15:0], s_tdata[31:16],
					s_tdata[47:32])};
				n_accepted++;
				s_fire = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (count_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected item: count %0d flag %0b", m_tdata[6:0], m_tdata[7]);
				end else begin
					want = count_q.pop_front();
					n_checked++;
					if (m_tdata[6:0] !== want.count || m_tdata[7] !== want.flagged) begin
						errors++;
						if (errors <= 10)
							$display("item %0d: count exp %0d got %0d, flag exp %0b got %0b",
								n_checked, want.count, m_tdata[6:0], want.flagged,
								m_tdata[7]);
					end
				end
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// window fills from empty under reset settings, then starts to slide
		send_idle = 12;
		recv_idle = 84;
		queue_item(0, -32768, 32767);
		queue_item(32767, 32767, -32768);
		queue_item(-32768, -32768, 32767);
		queue_item(-1, 0, 0);
		queue_item(1, 5, -5);
		queue_item(100, 100, 200);
		queue_item(150, 200, 100);
		queue_item(-32768, -32768, -32768);
		queue_item(32767, 32767, 32767);
		queue_item(50, -100, 300);
		queue_item(60, 300, -100);
		queue_item(-21846, 21845, -21846);
		queue_item(21845, -21846, 21845);
		queue_item(70, -100, 300);
		queue_item(80, -32768, 32767);
		queue_item(-2, -3, -1);
		queue_item(90, 300, -100);
		queue_item(32766, -32767, 32767);
		queue_item(-32767, -32768, 32766);
		queue_item(10, -100, 300);
		queue_item(20, -100, 300);
		queue_item(30, 300, -100);
		queue_item(0, 0, 0);
		queue_item(40, -32768, 32767);
		wait (n_checked == n_queued);

		set_config(1'b0, 7'd0);
		run_phase(250, 12, 84, 1'b0);
		set_config(1'b1, 7'd127);
		run_phase(250, 12, 84, 1'b0);
		set_config(1'b1, 7'd19);
		run_phase(250, 84, 12, 1'b1);
		set_config(1'b0, 7'd20);
		run_phase(250, 84, 12, 1'b0);
		set_config(1'b0, 7'd64);
		run_phase(200, 0, 0, 1'b0);
		set_config(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
		run_phase(200, 0, 0, 1'b0);
		set_config(1'b1, 7'($urandom_range(0, 20)));
		run_phase(225, 0, 0, 1'b0);

		repeat (WINDOW_LEN + 4) @(posedge clk);
		if (errors == 0 && count_q.size() == 0)
			$display("** window_violation_detector_unit: PASSED **");
		else
			$display("** window_violation_detector_unit: FAILED **");
		$finish;
	end

endmodule

// ===== window_violation_detector_unit.f =====
sv/wvd_pkg.sv
sv/wvd_cell.sv
sv/window_violation_detector_unit.sv
test/tb_window_violation_detector_unit.sv
